// File: rtl/hslrgb_pkg.sv
package hslrgb_pkg;

  // Fixed-point format of hue, saturation and lightness
  localparam int FRAC_BITS = 12;
  localparam int HUE_W     = 20;
  localparam int CTRL_W    = 13;
  localparam int LEVEL_W   = 8;
  localparam int MAX_LEVEL = 255;

  localparam logic [CTRL_W-1:0] ONE_FX  = CTRL_W'(1 << FRAC_BITS);
  localparam logic [CTRL_W-1:0] HALF_FX = CTRL_W'(1 << (FRAC_BITS - 1));

  // Channel levels in red, green, blue order
  typedef logic [2:0][LEVEL_W-1:0] chan_arr_t;

  // Packed widths of the stream payloads
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 24;

endpackage

// File: rtl/hslrgb_sector.sv
module hslrgb_sector (
  input  logic [hslrgb_pkg::HUE_W-1:0] hue,
  output hslrgb_pkg::chan_arr_t        ch
);

  localparam int INT_W = hslrgb_pkg::HUE_W - hslrgb_pkg::FRAC_BITS;
  localparam logic [7:0] TOP = 8'(hslrgb_pkg::MAX_LEVEL);

  logic [INT_W-1:0]                  hue_int;
  logic [hslrgb_pkg::FRAC_BITS-1:0]  hue_frac;
  logic [INT_W+7:0]                  quot_prod;
  logic [INT_W-1:0]                  quot;
  logic [INT_W+2:0]                  six_q;
  logic [2:0]                        sector;
  logic [hslrgb_pkg::FRAC_BITS+7:0]  ramp_prod;
  logic [7:0]                        ramp;

  assign hue_int  = hue[hslrgb_pkg::HUE_W-1:hslrgb_pkg::FRAC_BITS];
  assign hue_frac = hue[hslrgb_pkg::FRAC_BITS-1:0];

  // Sector = integer part mod 6, quotient by reciprocal 171/1024 (exact below 256)
  assign quot_prod = (INT_W+8)'(hue_int) * (INT_W+8)'(171);
  assign quot      = INT_W'(quot_prod[INT_W+7:10]);
  assign six_q     = (INT_W+3)'(quot) * (INT_W+3)'(6);
  assign sector    = 3'(hue_int - six_q[INT_W-1:0]);

  // Ramp = floor(255 * frac), as 256*frac - frac
  assign ramp_prod = {hue_frac, 8'b0} - (hslrgb_pkg::FRAC_BITS+8)'(hue_frac);
  assign ramp      = ramp_prod[hslrgb_pkg::FRAC_BITS+7:hslrgb_pkg::FRAC_BITS];

  // Place the full and ramping channels per sector
  always_comb begin
    ch = '0;
    case (sector)
      3'd0: begin
        ch[0] = TOP;
        ch[1] = ramp;
      end
      3'd1: begin
        ch[0] = TOP - ramp;
        ch[1] = TOP;
      end
      3'd2: begin
        ch[1] = TOP;
        ch[2] = ramp;
      end
      3'd3: begin
        ch[1] = TOP - ramp;
        ch[2] = TOP;
      end
      3'd4: begin
        ch[2] = TOP;
        ch[0] = ramp;
      end
      default: begin
        ch[2] = TOP - ramp;
        ch[0] = TOP;
      end
    endcase
  end

endmodule

// File: rtl/hsl_to_rgb_converter_top.sv
// Channel | Ports        | tdata fields, lowest bit first
// in      | in_t*        | hue_fixed[19:0], sat_fixed[32:20], light_fixed[45:33], zero pad
// out     | out_t*       | red_level[7:0], green_level[15:8], blue_level[23:16]
//
// Five register stages: sector/ramp, saturation products, blend and divide by
// three, lightness product, and lightness sum and clamp (or the scaled or
// unchanged level). One request is taken every cycle unless all stages are full and the output is stalled.
// Each stage stalls only when it holds a request and the next stage cannot take
// it, so bubbles close up under back-pressure and nothing is lost or repeated.
// rst_n (synchronous, active low) clears the valid bits only.
module hsl_to_rgb_converter_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // hue_fixed[19:0], sat_fixed[32:20], light_fixed[45:33]
  input  logic [hslrgb_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // red_level[7:0], green_level[15:8], blue_level[23:16]
  output logic [hslrgb_pkg::OUT_DATA_W-1:0]  out_tdata
);

  localparam int CW = hslrgb_pkg::CTRL_W;
  localparam logic [7:0] TOP = 8'(hslrgb_pkg::MAX_LEVEL);

  typedef enum logic [1:0] {
    LM_KEEP = 2'd0,
    LM_UP   = 2'd1,
    LM_DOWN = 2'd2
  } light_mode_t;

  // Stage ready chain
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5      = !v5_r || out_tready;
  assign rdy4      = !v4_r || rdy5;
  assign rdy3      = !v3_r || rdy4;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_tvalid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  // Stage 1: sector and ramp
  logic [hslrgb_pkg::HUE_W-1:0] in_hue;
  logic [CW-1:0]                in_sat, in_lit;
  hslrgb_pkg::chan_arr_t        ch1_nxt, ch1_r;
  logic [CW-1:0]                sat1_r, lit1_r;

  assign in_hue = in_tdata[19:0];
  assign in_sat = in_tdata[32:20];
  assign in_lit = in_tdata[45:33];

  hslrgb_sector u_sector (
    .hue (in_hue),
    .ch  (ch1_nxt)
  );

  always_ff @(posedge clk) begin
    if (rdy1) begin
      ch1_r  <= ch1_nxt;
      sat1_r <= in_sat;
      lit1_r <= in_lit;
    end
  end

  // Stage 2: sum weighted by (1 - s) and each channel weighted by s
  logic [9:0]                sum2;
  logic [12:0]               inv_sat2;
  logic [21:0]               psum2_nxt, psum2_r;
  logic [2:0][20:0]          pch2_nxt, pch2_r;
  hslrgb_pkg::chan_arr_t     ch2_r;
  logic                      byp2_r;
  logic [CW-1:0]             lit2_r;

  assign sum2      = 10'(ch1_r[0]) + 10'(ch1_r[1]) + 10'(ch1_r[2]);
  assign inv_sat2  = 13'(hslrgb_pkg::ONE_FX - sat1_r);
  assign psum2_nxt = 22'(sum2) * 22'(inv_sat2);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pch2_nxt[i] = 21'(ch1_r[i]) * 21'(sat1_r);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      psum2_r <= psum2_nxt;
      pch2_r  <= pch2_nxt;
      ch2_r   <= ch1_r;
      byp2_r  <= (sat1_r >= hslrgb_pkg::ONE_FX);
      lit2_r  <= lit1_r;
    end
  end

  // Stage 3: blend, drop fraction, divide by three; decode lightness
  logic [2:0][22:0]          mix3;
  logic [2:0][9:0]           whole3;
  logic [2:0][19:0]          recip3;
  hslrgb_pkg::chan_arr_t     ch3_nxt, ch3_r;
  light_mode_t               mode3_nxt, mode3_r;
  logic [13:0]               fac3_nxt, fac3_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mix3[i]   = 23'(psum2_r) + {1'b0, pch2_r[i], 1'b0} + 23'(pch2_r[i]);
      whole3[i] = mix3[i][21:12];
      // floor(v/3) as (v*683)>>11, exact for v below 1024
      recip3[i] = 20'(whole3[i]) * 20'(683);
      ch3_nxt[i] = byp2_r ? ch2_r[i] : recip3[i][18:11];
    end
  end

  always_comb begin
    mode3_nxt = LM_KEEP;
    fac3_nxt  = '0;
    if (lit2_r > hslrgb_pkg::HALF_FX) begin
      mode3_nxt = LM_UP;
      fac3_nxt  = {lit2_r, 1'b0} - 14'(hslrgb_pkg::ONE_FX);
    end else if (lit2_r < hslrgb_pkg::HALF_FX) begin
      mode3_nxt = LM_DOWN;
      fac3_nxt  = {lit2_r, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      ch3_r   <= ch3_nxt;
      mode3_r <= mode3_nxt;
      fac3_r  <= fac3_nxt;
    end
  end

  // Stage 4: lightness product toward white or black
  logic [2:0][21:0]          prod4_nxt, prod4_r;
  hslrgb_pkg::chan_arr_t     ch4_r;
  light_mode_t               mode4_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (mode3_r == LM_UP) begin
        prod4_nxt[i] = 22'(fac3_r) * 22'(TOP - ch3_r[i]);
      end else begin
        prod4_nxt[i] = 22'(fac3_r) * 22'(ch3_r[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      prod4_r <= prod4_nxt;
      ch4_r   <= ch3_r;
      mode4_r <= mode3_r;
    end
  end

  // Stage 5: add headroom share and clamp, take scaled level, or pass level through
  logic [2:0][10:0]          lift5;
  hslrgb_pkg::chan_arr_t     ch5_nxt, ch5_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lift5[i] = 11'(ch4_r[i]) + 11'(prod4_r[i][21:12]);
      case (mode4_r)
        LM_UP: begin
          ch5_nxt[i] = (lift5[i] > 11'(TOP)) ? TOP : lift5[i][7:0];
        end
        LM_DOWN: begin
          ch5_nxt[i] = prod4_r[i][19:12];
        end
        default: begin
          ch5_nxt[i] = ch4_r[i];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      ch5_r <= ch5_nxt;
    end
  end

  assign out_tvalid = v5_r;
  assign out_tdata  = {ch5_r[2], ch5_r[1], ch5_r[0]};

endmodule

// File: rtl/hslrgb_checker.sv
module hslrgb_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic [hslrgb_pkg::IN_DATA_W-1:0]   in_tdata,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [hslrgb_pkg::OUT_DATA_W-1:0]  out_tdata
);

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // An empty output stage means every stage can advance
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with an empty output stage");

  // A draining output never back-pressures the input
  a_drain_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while output drains");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed or dropped");

endmodule

bind hsl_to_rgb_converter_top hslrgb_checker u_hslrgb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
